@@ rtl/amrr_pkg.sv @@
package amrr_pkg;

    localparam int MCS_W      = 4;
    localparam int MCS_SLOTS  = 16;
    localparam int CNT_W      = 16;
    localparam int RUN_W      = 8;
    localparam int THR_W      = 8;
    localparam int TX_W       = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [MCS_W-1:0] START_TOP_MCS = 4'hd;
    localparam logic [RUN_W-1:0] RUN_MAX       = 8'hff;
    localparam logic [CNT_W-1:0] CNT_MAX       = 16'hffff;

    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_USABLE_MASK  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESH_MIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESH_MAX   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENOUGH_FRAME = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FEW_FRAME    = 3'd4;

    typedef struct packed {
        logic             found;
        logic [MCS_W-1:0] idx;
    } mcs_pick_t;

    function automatic mcs_pick_t lowest_set(logic [MCS_SLOTS-1:0] v);
        mcs_pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = MCS_SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p.found = 1'b1;
                p.idx   = MCS_W'(i);
            end
        end
        return p;
    endfunction

    function automatic mcs_pick_t highest_set(logic [MCS_SLOTS-1:0] v);
        mcs_pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = 0; i < MCS_SLOTS; i++)
        begin
            if (v[i])
            begin
                p.found = 1'b1;
                p.idx   = MCS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/amrr_if.sv @@
interface amrr_in_if;
    import amrr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [TX_W-1:0]  tx_frames;
    logic [TX_W-1:0]  tx_retries;

    modport source (output valid, output cmd, output tx_frames, output tx_retries,
                    input ready);
    modport sink   (input valid, input cmd, input tx_frames, input tx_retries,
                    output ready);
endinterface

interface amrr_out_if;
    import amrr_pkg::*;
    logic             valid;
    logic             ready;
    logic [MCS_W-1:0] mcs_index;
    logic             rate_changed;

    modport source (output valid, output mcs_index, output rate_changed, input ready);
    modport sink   (input valid, input mcs_index, input rate_changed, output ready);
endinterface

@@ rtl/amrr_ht_rate_control_top.sv @@
// The accepted item is held in an input register and its result in a result register.
// Throughput: one item per cycle; the whole rate decision is one combinational pass.
// A stalled result holds the pipeline; input ready follows output space.
// Reset (rst_n, async, active low) clears rate state and counters and loads
// register defaults: mask 1, thresholds 1 and 15, frame limits 100 and 10.
module amrr_ht_rate_control_top #(
    parameter int MCS_COUNT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    amrr_in_if.sink                           in_ch,
    amrr_out_if.source                        out_ch,
    input  logic                              cfg_wr_en,
    input  logic [amrr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [amrr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import amrr_pkg::*;

    localparam int MCS_LIM = (MCS_COUNT < MCS_SLOTS) ? MCS_COUNT : MCS_SLOTS;
    localparam logic [MCS_SLOTS:0] LIM_FULL = ((MCS_SLOTS+1)'(1) << MCS_LIM)
                                              - (MCS_SLOTS+1)'(1);
    localparam logic [MCS_SLOTS-1:0] LIM_MASK = LIM_FULL[MCS_SLOTS-1:0];

    // configuration
    logic [MCS_SLOTS-1:0] mask_reg;
    logic [THR_W-1:0]     tmin_reg;
    logic [THR_W-1:0]     tmax_reg;
    logic [CNT_W-1:0]     enough_reg;
    logic [CNT_W-1:0]     few_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= 16'd1;
            tmin_reg   <= 8'd1;
            tmax_reg   <= 8'd15;
            enough_reg <= 16'd100;
            few_reg    <= 16'd10;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_USABLE_MASK:  mask_reg   <= cfg_wdata;
                CFG_THRESH_MIN:   tmin_reg   <= cfg_wdata[THR_W-1:0];
                CFG_THRESH_MAX:   tmax_reg   <= cfg_wdata[THR_W-1:0];
                CFG_ENOUGH_FRAME: enough_reg <= cfg_wdata;
                CFG_FEW_FRAME:    few_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic             in_vld_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [TX_W-1:0]  frames_in_reg;
    logic [TX_W-1:0]  retries_in_reg;
    logic             out_vld_reg;
    logic [MCS_W-1:0] out_mcs_reg;
    logic             out_chg_reg;
    logic             adv;
    logic             fire;

    assign adv         = !out_vld_reg || out_ch.ready;
    assign fire        = in_vld_reg && adv;
    assign in_ch.ready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_vld_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            cmd_reg        <= in_ch.cmd;
            frames_in_reg  <= in_ch.tx_frames;
            retries_in_reg <= in_ch.tx_retries;
        end
    end

    // rate state
    logic [MCS_W-1:0] mcs_reg,    mcs_next;
    logic [RUN_W-1:0] run_reg,    run_next;
    logic             recov_reg,  recov_next;
    logic [CNT_W-1:0] frame_reg,  frame_next;
    logic [CNT_W-1:0] retry_reg,  retry_next;
    logic [THR_W-1:0] limit_reg,  limit_next;
    logic             chg_next;

    logic [MCS_SLOTS-1:0] usable;
    logic [MCS_SLOTS-1:0] above;
    logic [MCS_SLOTS-1:0] below;
    logic [MCS_SLOTS-1:0] start_set;
    mcs_pick_t            up_pick;
    mcs_pick_t            down_pick;
    mcs_pick_t            start_pick;
    logic [CNT_W:0]       frame_sum;
    logic [CNT_W:0]       retry_sum;
    logic [CNT_W+3:0]     retry_x10;
    logic [CNT_W+1:0]     retry_x3;
    logic                 success;
    logic                 failure;
    logic                 enough;
    logic                 not_few;
    logic [RUN_W-1:0]     run_inc;
    logic [THR_W:0]       limit_inc;

    always_comb
    begin
        usable = mask_reg & LIM_MASK;
        for (int i = 0; i < MCS_SLOTS; i++)
        begin
            above[i]     = usable[i] && (MCS_W'(i) > mcs_reg);
            below[i]     = usable[i] && (MCS_W'(i) < mcs_reg);
            start_set[i] = usable[i] && (i >= 1) && (MCS_W'(i) <= START_TOP_MCS);
        end
    end

    assign up_pick    = lowest_set(above);
    assign down_pick  = highest_set(below);
    assign start_pick = highest_set(start_set);

    assign frame_sum = {1'b0, frame_reg} + (CNT_W+1)'(frames_in_reg);
    assign retry_sum = {1'b0, retry_reg} + (CNT_W+1)'(retries_in_reg);
    assign retry_x10 = ({4'b0, retry_reg} << 3) + ({4'b0, retry_reg} << 1);
    assign retry_x3  = {2'b0, retry_reg} + {1'b0, retry_reg, 1'b0};
    assign success   = retry_x10 < {4'b0, frame_reg};
    assign failure   = retry_x3 > {2'b0, frame_reg};
    assign enough    = frame_reg > enough_reg;
    assign not_few   = frame_reg > few_reg;
    assign run_inc   = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + RUN_W'(1);
    assign limit_inc = {1'b0, limit_reg} + (THR_W+1)'(1);

    always_comb
    begin
        mcs_next   = mcs_reg;
        run_next   = run_reg;
        recov_next = recov_reg;
        frame_next = frame_reg;
        retry_next = retry_reg;
        limit_next = limit_reg;
        chg_next   = 1'b0;
        unique case (cmd_reg)
            CMD_REPORT:
            begin
                frame_next = frame_sum[CNT_W] ? CNT_MAX : frame_sum[CNT_W-1:0];
                retry_next = retry_sum[CNT_W] ? CNT_MAX : retry_sum[CNT_W-1:0];
            end
            CMD_START:
            begin
                run_next   = '0;
                recov_next = 1'b0;
                frame_next = '0;
                retry_next = '0;
                limit_next = tmin_reg;
                mcs_next   = start_pick.found ? start_pick.idx : '0;
                chg_next   = mcs_next != mcs_reg;
            end
            CMD_TICK:
            begin
                if (success && enough)
                begin
                    if (run_inc >= limit_reg && up_pick.found)
                    begin
                        recov_next = 1'b1;
                        run_next   = '0;
                        mcs_next   = up_pick.idx;
                        chg_next   = 1'b1;
                    end
                    else
                    begin
                        recov_next = 1'b0;
                        run_next   = run_inc;
                    end
                end
                else if (not_few && failure)
                begin
                    run_next = '0;
                    if (down_pick.found)
                    begin
                        if (recov_reg)
                        begin
                            limit_next = (limit_inc > {1'b0, tmax_reg}) ? tmax_reg
                                                                        : limit_inc[THR_W-1:0];
                        end
                        else
                        begin
                            limit_next = tmin_reg;
                        end
                        mcs_next = down_pick.idx;
                        chg_next = 1'b1;
                    end
                    recov_next = 1'b0;
                end
                if (enough || chg_next)
                begin
                    frame_next = '0;
                    retry_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg     <= '0;
            run_reg     <= '0;
            recov_reg   <= 1'b0;
            frame_reg   <= '0;
            retry_reg   <= '0;
            limit_reg   <= 8'd1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                mcs_reg   <= mcs_next;
                run_reg   <= run_next;
                recov_reg <= recov_next;
                frame_reg <= frame_next;
                retry_reg <= retry_next;
                limit_reg <= limit_next;
            end
            if (adv)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_mcs_reg <= mcs_next;
            out_chg_reg <= chg_next;
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.mcs_index    = out_mcs_reg;
    assign out_ch.rate_changed = out_chg_reg;

`ifndef SYNTH
    a_mcs_moves_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        (mcs_reg != $past(mcs_reg)) |-> $past(fire))
        else $error("rate moved without an item");

    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_mcs_reg == mcs_reg))
        else $error("result mcs differs from current rate");

    a_change_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && chg_next && cmd_reg == CMD_TICK) |=> (frame_reg == '0 && retry_reg == '0))
        else $error("window not cleared after rate change");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_reg == CMD_START) |=> (run_reg == '0 && !recov_reg))
        else $error("start did not clear adaptation state");
`endif

endmodule
